FILE: hw/rtl/swb_pkg.sv
// swb_pkg: shared types, constants and small arithmetic helpers for the
// swirl warp core. No dependencies.
`default_nettype none

package swb_pkg;

    localparam int MAX_ROWS_DEF = 256;
    localparam int MAX_COLS_DEF = 256;

    // config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TWIST    = 2'd2;

    localparam logic [8:0]  NUM_ROWS_RST = 9'd256;
    localparam logic [8:0]  NUM_COLS_RST = 9'd256;
    localparam logic [15:0] TWIST_RST    = 16'd572;

    // word kinds
    localparam logic ACT_STORE   = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    localparam int FIFO_DEPTH   = 4;
    localparam int SQRT_STEPS   = 17;
    localparam int CORDIC_STEPS = 14;

    localparam logic signed [19:0] CORDIC_GAIN    = 20'sd39797;
    localparam logic [29:0]        INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic signed [16:0] QUARTER_TURN   = 17'sd16384;
    localparam logic signed [16:0] HALF_TURN      = 17'sd32768;

    typedef struct packed {
        logic        act;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [23:0] rgb;
    } item_t;

    typedef struct packed {
        item_t              item;
        logic signed [8:0]  di;
        logic signed [8:0]  dj;
        logic [16:0]        dsq;
    } job_t;

    // effective geometry; the user keeps it stable while words are in flight, the core does not enforce it
    typedef struct packed {
        logic [8:0]  rows;
        logic [8:0]  cols;
        logic [15:0] twist;
    } geom_t;

    // arctangent of 2^-i in Q16 turns
    function automatic logic signed [16:0] atan_turns(input int i);
        logic signed [16:0] v;
        case (i)
            0:       v = 17'sd8192;
            1:       v = 17'sd4836;
            2:       v = 17'sd2555;
            3:       v = 17'sd1297;
            4:       v = 17'sd651;
            5:       v = 17'sd326;
            6:       v = 17'sd163;
            7:       v = 17'sd81;
            8:       v = 17'sd41;
            9:       v = 17'sd20;
            10:      v = 17'sd10;
            11:      v = 17'sd5;
            12:      v = 17'sd3;
            13:      v = 17'sd1;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

    // ((256-f)*a + f*b) >> 8
    function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] f);
        logic [8:0]  wa;
        logic [16:0] pa;
        logic [16:0] pb;
        logic [16:0] acc;
        wa  = 9'd256 - {1'b0, f};
        pa  = wa * a;
        pb  = f * b;
        acc = pa + pb;
        return acc[15:8];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/swb_ram.sv
// swb_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`default_nettype none

module swb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/swb_front.sv
// swb_front: input register; classifies words and works out the centre
// offset and squared distance. Depends on swb_pkg.
`default_nettype none

module swb_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          action,
    input  wire logic [7:0]    row,
    input  wire logic [7:0]    col,
    input  wire logic [7:0]    red_in,
    input  wire logic [7:0]    green_in,
    input  wire logic [7:0]    blue_in,
    input  wire swb_pkg::geom_t geom,
    output logic               push,
    output swb_pkg::job_t      push_job,
    input  wire logic          fifo_full
);

    logic               valid_reg;
    swb_pkg::job_t      job_reg;
    swb_pkg::job_t      job_next;
    logic signed [8:0]  di_c;
    logic signed [8:0]  dj_c;
    logic signed [17:0] sq_i;
    logic signed [17:0] sq_j;
    logic signed [17:0] sq_sum;

    assign in_ready = !valid_reg || !fifo_full;
    assign push     = valid_reg && !fifo_full;
    assign push_job = job_reg;

    always_comb
    begin
        di_c   = $signed({1'b0, row}) - $signed({1'b0, geom.rows[8:1]});
        dj_c   = $signed({1'b0, col}) - $signed({1'b0, geom.cols[8:1]});
        sq_i   = di_c * di_c;
        sq_j   = dj_c * dj_c;
        sq_sum = sq_i + sq_j;
        job_next.item.act = action;
        job_next.item.row = row;
        job_next.item.col = col;
        job_next.item.rgb = {red_in, green_in, blue_in};
        job_next.di       = di_c;
        job_next.dj       = dj_c;
        job_next.dsq      = sq_sum[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            job_reg <= job_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/swb_fifo.sv
// swb_fifo: short queue of jobs between front and back.
// Depends on swb_pkg.
`default_nettype none

module swb_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire swb_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output swb_pkg::job_t      pop_job,
    output logic               empty
);

    localparam int PW = $clog2(swb_pkg::FIFO_DEPTH);

    swb_pkg::job_t mem_reg [swb_pkg::FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign full    = (count_reg == (PW+1)'(swb_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/swb_back.sv
// swb_back: warp pipeline - square root, angle, CORDIC, rotation, banked
// pixel store and bilinear blend. Depends on swb_pkg and swb_ram.
`default_nettype none

module swb_back #(
    parameter int MAX_ROWS = swb_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = swb_pkg::MAX_COLS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire swb_pkg::geom_t geom,
    input  wire logic           job_avail,
    input  wire swb_pkg::job_t  job,
    output logic                job_take,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_row,
    output logic [7:0]          out_col,
    output logic [7:0]          red_out,
    output logic [7:0]          green_out,
    output logic [7:0]          blue_out,
    output logic                inside_res
);

    localparam int HALF_ROWS  = (MAX_ROWS + 1) / 2;
    localparam int HALF_COLS  = (MAX_COLS + 1) / 2;
    localparam int BANK_DEPTH = HALF_ROWS * HALF_COLS;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int SQ = swb_pkg::SQRT_STEPS;
    localparam int CS = swb_pkg::CORDIC_STEPS;

    typedef struct packed {
        logic              v;
        swb_pkg::item_t    item;
        logic signed [8:0] di;
        logic signed [8:0] dj;
    } ctx_t;

    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign job_take = en && job_avail;

    // ---------------- square root, one digit per stage ----------------
    ctx_t        sq_ctx_reg  [SQ+1];
    logic [33:0] sq_val_reg  [SQ+1];
    logic [18:0] sq_rem_reg  [SQ+1];
    logic [16:0] sq_root_reg [SQ+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_ctx_reg[0] <= '0;
        end
        else if (en)
        begin
            sq_ctx_reg[0] <= {job_take, job.item, job.di, job.dj};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_val_reg[0]  <= {1'b0, job.dsq, 16'b0};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQ; k++)
    begin : g_sqrt
        logic [20:0] acc;
        logic [20:0] trial;
        logic [20:0] diff;
        logic        fits;

        always_comb
        begin
            acc   = {sq_rem_reg[k], sq_val_reg[k][33:32]};
            trial = {2'b00, sq_root_reg[k], 2'b01};
            diff  = acc - trial;
            fits  = (acc >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_ctx_reg[k+1] <= '0;
            end
            else if (en)
            begin
                sq_ctx_reg[k+1] <= sq_ctx_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_val_reg[k+1]  <= {sq_val_reg[k][31:0], 2'b00};
                sq_rem_reg[k+1]  <= fits ? diff[18:0] : acc[18:0];
                sq_root_reg[k+1] <= {sq_root_reg[k][15:0], fits};
            end
        end
    end

    // ---------------- angle and phase ----------------
    ctx_t        m1_ctx_reg;
    logic [32:0] m1_prod_reg;
    ctx_t        m2_ctx_reg;
    logic [15:0] m2_phase_reg;
    logic [54:0] ph_full;

    assign ph_full = {30'b0, m1_prod_reg[32:8]} * {25'b0, swb_pkg::INV_TWO_PI_Q32};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_ctx_reg <= '0;
            m2_ctx_reg <= '0;
        end
        else if (en)
        begin
            m1_ctx_reg <= sq_ctx_reg[SQ];
            m2_ctx_reg <= m1_ctx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_prod_reg  <= {17'b0, geom.twist} * {16'b0, sq_root_reg[SQ]};
            m2_phase_reg <= ph_full[47:32];
        end
    end

    // ---------------- quadrant fold and CORDIC ----------------
    ctx_t               co_ctx_reg [CS+1];
    logic signed [19:0] co_x_reg   [CS+1];
    logic signed [19:0] co_y_reg   [CS+1];
    logic signed [16:0] co_p_reg   [CS+1];
    logic               co_neg_reg [CS+1];
    logic signed [16:0] p_raw;
    logic signed [16:0] p_fold;
    logic               neg_fold;

    always_comb
    begin
        p_raw    = $signed({m2_phase_reg[15], m2_phase_reg});
        p_fold   = p_raw;
        neg_fold = 1'b0;
        if (p_raw > swb_pkg::QUARTER_TURN)
        begin
            p_fold   = p_raw - swb_pkg::HALF_TURN;
            neg_fold = 1'b1;
        end
        else if (p_raw < -swb_pkg::QUARTER_TURN)
        begin
            p_fold   = p_raw + swb_pkg::HALF_TURN;
            neg_fold = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            co_ctx_reg[0] <= '0;
        end
        else if (en)
        begin
            co_ctx_reg[0] <= m2_ctx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            co_x_reg[0]   <= swb_pkg::CORDIC_GAIN;
            co_y_reg[0]   <= '0;
            co_p_reg[0]   <= p_fold;
            co_neg_reg[0] <= neg_fold;
        end
    end

    for (genvar k = 0; k < CS; k++)
    begin : g_cordic
        logic signed [19:0] xs;
        logic signed [19:0] ys;

        assign xs = co_x_reg[k] >>> k;
        assign ys = co_y_reg[k] >>> k;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                co_ctx_reg[k+1] <= '0;
            end
            else if (en)
            begin
                co_ctx_reg[k+1] <= co_ctx_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                co_neg_reg[k+1] <= co_neg_reg[k];
                if (!co_p_reg[k][16])
                begin
                    co_x_reg[k+1] <= co_x_reg[k] - ys;
                    co_y_reg[k+1] <= co_y_reg[k] + xs;
                    co_p_reg[k+1] <= co_p_reg[k] - swb_pkg::atan_turns(k);
                end
                else
                begin
                    co_x_reg[k+1] <= co_x_reg[k] + ys;
                    co_y_reg[k+1] <= co_y_reg[k] - xs;
                    co_p_reg[k+1] <= co_p_reg[k] + swb_pkg::atan_turns(k);
                end
            end
        end
    end

    // ---------------- rotation ----------------
    ctx_t               n_ctx_reg;
    logic signed [19:0] n_cs_reg;
    logic signed [19:0] n_sn_reg;
    ctx_t               r1_ctx_reg;
    logic signed [28:0] r1_dics_reg;
    logic signed [28:0] r1_djsn_reg;
    logic signed [28:0] r1_disn_reg;
    logic signed [28:0] r1_djcs_reg;
    ctx_t               r2_ctx_reg;
    logic signed [21:0] r2_sr_reg;
    logic signed [21:0] r2_sc_reg;
    logic signed [29:0] cx_term;
    logic signed [29:0] cy_term;
    logic signed [29:0] sum_r;
    logic signed [29:0] sum_c;

    always_comb
    begin
        cx_term = {6'b0, geom.rows[8:1], 16'b0};
        cy_term = {6'b0, geom.cols[8:1], 16'b0};
        sum_r   = r1_dics_reg + r1_djsn_reg + cx_term;
        sum_c   = r1_djcs_reg - r1_disn_reg + cy_term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_ctx_reg  <= '0;
            r1_ctx_reg <= '0;
            r2_ctx_reg <= '0;
        end
        else if (en)
        begin
            n_ctx_reg  <= co_ctx_reg[CS];
            r1_ctx_reg <= n_ctx_reg;
            r2_ctx_reg <= r1_ctx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_cs_reg    <= co_neg_reg[CS] ? -co_x_reg[CS] : co_x_reg[CS];
            n_sn_reg    <= co_neg_reg[CS] ? -co_y_reg[CS] : co_y_reg[CS];
            r1_dics_reg <= n_ctx_reg.di * n_cs_reg;
            r1_djsn_reg <= n_ctx_reg.dj * n_sn_reg;
            r1_disn_reg <= n_ctx_reg.di * n_sn_reg;
            r1_djcs_reg <= n_ctx_reg.dj * n_cs_reg;
            r2_sr_reg   <= sum_r[29:8];
            r2_sc_reg   <= sum_c[29:8];
        end
    end

    // ---------------- neighbours and bank addresses ----------------
    ctx_t               i_ctx_reg;
    logic               i_inside_reg;
    logic [7:0]         i_fr_reg;
    logic [7:0]         i_fc_reg;
    logic [3:0]         i_par_reg;      // {rf0, rc0, cf0, cc0}
    logic [BANK_AW-1:0] i_addr_reg [4];
    logic               inside_c;
    logic [8:0]         rf;
    logic [8:0]         cf;
    logic [9:0]         rc_raw;
    logic [9:0]         cc_raw;
    logic [9:0]         rows_m1;
    logic [9:0]         cols_m1;
    logic [8:0]         rc;
    logic [8:0]         cc;
    logic [7:0]         fr_eff;
    logic [7:0]         fc_eff;
    logic [BANK_AW-1:0] addr_c [4];
    logic               wr_ok;
    logic [BANK_AW-1:0] wr_addr;
    logic [1:0]         wr_bank;

    always_comb
    begin
        inside_c = !r2_sr_reg[21] && (r2_sr_reg[20:0] < {4'b0, geom.rows, 8'b0})
                && !r2_sc_reg[21] && (r2_sc_reg[20:0] < {4'b0, geom.cols, 8'b0});
        rf      = r2_sr_reg[16:8];
        cf      = r2_sc_reg[16:8];
        rc_raw  = {1'b0, rf} + {9'b0, (r2_sr_reg[7:0] != 8'd0)};
        cc_raw  = {1'b0, cf} + {9'b0, (r2_sc_reg[7:0] != 8'd0)};
        rows_m1 = {1'b0, geom.rows} - 10'd1;
        cols_m1 = {1'b0, geom.cols} - 10'd1;
        rc      = (rc_raw > rows_m1) ? rows_m1[8:0] : rc_raw[8:0];
        cc      = (cc_raw > cols_m1) ? cols_m1[8:0] : cc_raw[8:0];
        fr_eff  = (rc == rf) ? 8'd0 : r2_sr_reg[7:0];
        fc_eff  = (cc == cf) ? 8'd0 : r2_sc_reg[7:0];
        wr_ok   = (32'(r2_ctx_reg.item.row) < 32'(MAX_ROWS))
               && (32'(r2_ctx_reg.item.col) < 32'(MAX_COLS));
        wr_bank = {r2_ctx_reg.item.row[0], r2_ctx_reg.item.col[0]};
        wr_addr = BANK_AW'((32'(r2_ctx_reg.item.row) >> 1) * HALF_COLS
                           + (32'(r2_ctx_reg.item.col) >> 1));
    end

    // bank {pr,pc} serves whichever neighbour row and column have that parity
    for (genvar b = 0; b < 4; b++)
    begin : g_addr
        logic [8:0] rsel;
        logic [8:0] csel;

        always_comb
        begin
            rsel = (rf[0] == b[1]) ? rf : rc;
            csel = (cf[0] == b[0]) ? cf : cc;
            addr_c[b] = BANK_AW'((32'(rsel) >> 1) * HALF_COLS + (32'(csel) >> 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_ctx_reg <= '0;
        end
        else if (en)
        begin
            i_ctx_reg <= r2_ctx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_inside_reg <= inside_c;
            i_fr_reg     <= fr_eff;
            i_fc_reg     <= fc_eff;
            i_par_reg    <= {rf[0], rc[0], cf[0], cc[0]};
            for (int b = 0; b < 4; b++)
            begin
                i_addr_reg[b] <= addr_c[b];
            end
        end
    end

    // ---------------- pixel store: four banks by row/col parity ----------------
    // Stores write at the same stage where requests read, so order is kept.
    logic               st_we;
    logic [BANK_AW-1:0] st_addr_reg;
    logic [1:0]         st_bank_reg;
    logic               st_ok_reg;
    logic [23:0]        bank_rdata [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_addr_reg <= wr_addr;
            st_bank_reg <= wr_bank;
            st_ok_reg   <= wr_ok;
        end
    end

    assign st_we = en && i_ctx_reg.v && (i_ctx_reg.item.act == swb_pkg::ACT_STORE)
                && st_ok_reg;

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        swb_ram #(
            .WIDTH (24),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (st_we && (st_bank_reg == 2'(b))),
            .waddr (st_addr_reg),
            .wdata (i_ctx_reg.item.rgb),
            .re    (en),
            .raddr (i_addr_reg[b]),
            .rdata (bank_rdata[b])
        );
    end

    ctx_t       rd_ctx_reg;
    logic       rd_inside_reg;
    logic [7:0] rd_fr_reg;
    logic [7:0] rd_fc_reg;
    logic [3:0] rd_par_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ctx_reg <= '0;
        end
        else if (en)
        begin
            rd_ctx_reg <= i_ctx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_inside_reg <= i_inside_reg;
            rd_fr_reg     <= i_fr_reg;
            rd_fc_reg     <= i_fc_reg;
            rd_par_reg    <= i_par_reg;
        end
    end

    // ---------------- blend ----------------
    logic [23:0] p00;
    logic [23:0] p01;
    logic [23:0] p10;
    logic [23:0] p11;
    ctx_t        l1_ctx_reg;
    logic        l1_inside_reg;
    logic [7:0]  l1_fr_reg;
    logic [23:0] l1_top_reg;
    logic [23:0] l1_bot_reg;
    logic [23:0] top_c;
    logic [23:0] bot_c;

    always_comb
    begin
        p00 = bank_rdata[{rd_par_reg[3], rd_par_reg[1]}];
        p01 = bank_rdata[{rd_par_reg[3], rd_par_reg[0]}];
        p10 = bank_rdata[{rd_par_reg[2], rd_par_reg[1]}];
        p11 = bank_rdata[{rd_par_reg[2], rd_par_reg[0]}];
        for (int c = 0; c < 3; c++)
        begin
            top_c[c*8 +: 8] = swb_pkg::lerp8(p00[c*8 +: 8], p01[c*8 +: 8], rd_fc_reg);
            bot_c[c*8 +: 8] = swb_pkg::lerp8(p10[c*8 +: 8], p11[c*8 +: 8], rd_fc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_ctx_reg <= '0;
        end
        else if (en)
        begin
            l1_ctx_reg <= rd_ctx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l1_inside_reg <= rd_inside_reg;
            l1_fr_reg     <= rd_fr_reg;
            l1_top_reg    <= top_c;
            l1_bot_reg    <= bot_c;
        end
    end

    // ---------------- output register ----------------
    logic [23:0] mix_c;
    logic [23:0] rgb_out_reg;
    logic [7:0]  out_row_reg;
    logic [7:0]  out_col_reg;
    logic        inside_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            mix_c[c*8 +: 8] = swb_pkg::lerp8(l1_top_reg[c*8 +: 8], l1_bot_reg[c*8 +: 8],
                                             l1_fr_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= l1_ctx_reg.v && (l1_ctx_reg.item.act == swb_pkg::ACT_REQUEST);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_row_reg <= l1_ctx_reg.item.row;
            out_col_reg <= l1_ctx_reg.item.col;
            inside_reg  <= l1_inside_reg;
            rgb_out_reg <= l1_inside_reg ? mix_c : 24'd0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign red_out    = rgb_out_reg[23:16];
    assign green_out  = rgb_out_reg[15:8];
    assign blue_out   = rgb_out_reg[7:0];
    assign inside_res = inside_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/swirl_warp_bilinear_core.sv
// swirl_warp_bilinear_core: top level of the swirl warp with bilinear blend.
// Depends on swb_pkg, swb_front, swb_fifo, swb_back (and swb_ram below it).
//
//  channel  direction  handshake              word
//  ------   ---------  ---------------------  ---------------------------------
//  in       sink       in_valid / in_ready    action, row, col, red/green/blue_in
//  out      source     out_valid / out_ready  out_row, out_col, rgb out, inside
//  cfg      sink       cfg_we (no wait)       cfg_idx, cfg_wdata
//
// One word per cycle sustained while the output is not stalled, stores and
// requests alike. The depth is set mainly by the 17-stage square root and the
// 14-stage CORDIC. Stores ride the same pipe and write the banked store at the
// read stage, so reads see all earlier writes.
// Reset clears control state only; the pixel store holds garbage until written.
// A stalled output freezes the back pipe; the input register and the 4-deep
// queue take up to five more words before in_ready drops.
`default_nettype none

module swirl_warp_bilinear_core #(
    parameter int MAX_ROWS = swb_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = swb_pkg::MAX_COLS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           action,
    input  wire logic [7:0]                     row,
    input  wire logic [7:0]                     col,
    input  wire logic [7:0]                     red_in,
    input  wire logic [7:0]                     green_in,
    input  wire logic [7:0]                     blue_in,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [7:0]                          out_row,
    output logic [7:0]                          out_col,
    output logic [7:0]                          red_out,
    output logic [7:0]                          green_out,
    output logic [7:0]                          blue_out,
    output logic                                inside_res,
    input  wire logic                           cfg_we,
    input  wire logic [swb_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [swb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // config registers
    logic [8:0]  num_rows_reg;
    logic [8:0]  num_cols_reg;
    logic [15:0] twist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= swb_pkg::NUM_ROWS_RST;
            num_cols_reg <= swb_pkg::NUM_COLS_RST;
            twist_reg    <= swb_pkg::TWIST_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                swb_pkg::CFG_NUM_ROWS: num_rows_reg <= cfg_wdata[8:0];
                swb_pkg::CFG_NUM_COLS: num_cols_reg <= cfg_wdata[8:0];
                swb_pkg::CFG_TWIST:    twist_reg    <= cfg_wdata;
                default:               ;
            endcase
        end
    end

    // effective size: clamp to 1..MAX
    swb_pkg::geom_t geom;

    always_comb
    begin
        if (num_rows_reg == 9'd0)
            geom.rows = 9'd1;
        else if (32'(num_rows_reg) > 32'(MAX_ROWS))
            geom.rows = 9'(MAX_ROWS);
        else
            geom.rows = num_rows_reg;

        if (num_cols_reg == 9'd0)
            geom.cols = 9'd1;
        else if (32'(num_cols_reg) > 32'(MAX_COLS))
            geom.cols = 9'(MAX_COLS);
        else
            geom.cols = num_cols_reg;

        geom.twist = twist_reg;
    end

    logic          push;
    swb_pkg::job_t push_job;
    logic          fifo_full;
    logic          fifo_empty;
    logic          pop;
    swb_pkg::job_t pop_job;

    swb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .row       (row),
        .col       (col),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .geom      (geom),
        .push      (push),
        .push_job  (push_job),
        .fifo_full (fifo_full)
    );

    swb_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (fifo_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (fifo_empty)
    );

    swb_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .geom       (geom),
        .job_avail  (!fifo_empty),
        .job        (pop_job),
        .job_take   (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_row    (out_row),
        .out_col    (out_col),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .inside_res (inside_res)
    );

endmodule

`default_nettype wire

FILE: tb/swirl_warp_bilinear_core_tb.sv
// swirl_warp_bilinear_core_tb: self-checking testbench for the swirl warp core.
// Depends on swb_pkg and swirl_warp_bilinear_core; predicts every result itself.
`timescale 1ns / 100ps

module swirl_warp_bilinear_core_tb;

    localparam logic [swb_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // index past the registers
    localparam int DRAIN_CYCLES = 80;                    // longer than the pipe is deep
    localparam int CYCLE_LIMIT  = 600000;

    // CORDIC arctangent steps, Q16 turns
    localparam int ARC_STEP [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                     41, 20, 10, 5, 3, 1};

    typedef struct packed {
        logic [7:0] orow;
        logic [7:0] ocol;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       in_img;
    } warp_px_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic action = swb_pkg::ACT_STORE;
    logic [7:0] row = '0, col = '0, red_in = '0, green_in = '0, blue_in = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [7:0] out_row, out_col, red_out, green_out, blue_out;
    logic inside_res;
    logic cfg_we = 1'b0;
    logic [swb_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [swb_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    swirl_warp_bilinear_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .row(row), .col(col),
        .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_row(out_row), .out_col(out_col),
        .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
        .inside_res(inside_res),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow image and geometry
    logic [23:0] image_px [65536];
    bit          image_set [65536];
    logic [8:0]  geo_rows = swb_pkg::NUM_ROWS_RST;
    logic [8:0]  geo_cols = swb_pkg::NUM_COLS_RST;
    logic [15:0] geo_twist = swb_pkg::TWIST_RST;

    warp_px_t pending_px [$];
    int errors = 0;
    int cycles = 0;

    // idling knobs, percent per cycle
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int recv_hold = 0;  // long receiver hold-off, counted down below

    function automatic logic [7:0] blend8(input int a, input int b, input int f);
        return 8'(((256 - f) * a + f * b) >> 8);
    endfunction

    // Work out the warped pixel for (r, c). Returns 0 when the blend would
    // touch a store entry that was never written; such requests are not sent.
    function automatic bit warp_pixel(input logic [7:0] r, input logic [7:0] c,
                                      output warp_px_t w);
        longint rows_e, cols_e, cx, cy, di, dj, p, x, y, xs, ys, sr, sc;
        longint rf, cf, rc, cc, fr, fc;
        longint unsigned v, root, bitv, ang, ph;
        bit neg;
        int a00, a01, a10, a11, sh;
        logic [7:0] top, bot, chan [3];
        rows_e = (geo_rows == 0) ? 1 : ((geo_rows > 256) ? 256 : geo_rows);
        cols_e = (geo_cols == 0) ? 1 : ((geo_cols > 256) ? 256 : geo_cols);
        cx = rows_e / 2;
        cy = cols_e / 2;
        di = longint'(r) - cx;
        dj = longint'(c) - cy;
        // exact integer square root of the Q16 squared distance
        v = longint'(di * di + dj * dj) << 16;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        ang = (longint'(geo_twist) * root) >> 8;
        ph = ((ang * 64'd683565276) >> 32) & 64'hFFFF;
        p = (ph >= 32768) ? longint'(ph) - 65536 : longint'(ph);
        neg = 1'b0;
        if (p > 16384)
        begin
            p -= 32768;
            neg = 1'b1;
        end
        else if (p < -16384)
        begin
            p += 32768;
            neg = 1'b1;
        end
        x = 39797;
        y = 0;
        for (int i = 0; i < 14; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (p >= 0)
            begin
                x -= ys;
                y += xs;
                p -= ARC_STEP[i];
            end
            else
            begin
                x += ys;
                y -= xs;
                p += ARC_STEP[i];
            end
        end
        if (neg)
        begin
            x = -x;
            y = -y;
        end
        sr = (di * x + dj * y + cx * 65536) >>> 8;
        sc = (-di * y + dj * x + cy * 65536) >>> 8;
        w = '0;
        w.orow = r;
        w.ocol = c;
        if (!(sr >= 0 && sr < rows_e * 256 && sc >= 0 && sc < cols_e * 256))
            return 1'b1;
        rf = sr >> 8;
        cf = sc >> 8;
        fr = sr & 255;
        fc = sc & 255;
        rc = (fr != 0) ? rf + 1 : rf;
        cc = (fc != 0) ? cf + 1 : cf;
        if (rc > rows_e - 1)
            rc = rows_e - 1;
        if (cc > cols_e - 1)
            cc = cols_e - 1;
        // zero divisor: all weight on the floor neighbor
        if (rc == rf)
            fr = 0;
        if (cc == cf)
            fc = 0;
        if (!image_set[rf * 256 + cf] || !image_set[rf * 256 + cc] ||
            !image_set[rc * 256 + cf] || !image_set[rc * 256 + cc])
            return 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            sh = 16 - 8 * k;
            a00 = (image_px[rf * 256 + cf] >> sh) & 255;
            a01 = (image_px[rf * 256 + cc] >> sh) & 255;
            a10 = (image_px[rc * 256 + cf] >> sh) & 255;
            a11 = (image_px[rc * 256 + cc] >> sh) & 255;
            top = blend8(a00, a01, int'(fc));
            bot = blend8(a10, a11, int'(fc));
            chan[k] = blend8(top, bot, int'(fr));
        end
        w.red = chan[0];
        w.green = chan[1];
        w.blue = chan[2];
        w.in_img = 1'b1;
        return 1'b1;
    endfunction

    // Offer one word and hold it until taken; predict at acceptance.
    task automatic send_word(input logic act, input logic [7:0] r, input logic [7:0] c,
                             input logic [23:0] rgb);
        warp_px_t w;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        row <= r;
        col <= c;
        {red_in, green_in, blue_in} <= rgb;
        do
            @(posedge clk);
        while (!in_ready);
        if (act == swb_pkg::ACT_STORE)
        begin
            image_px[{r, c}] = rgb;
            image_set[{r, c}] = 1'b1;
        end
        else
        begin
            void'(warp_pixel(r, c, w));
            pending_px.push_back(w);
        end
        @(negedge clk);
    endtask

    // Send a request only if its blend reads written pixels.
    task automatic try_request(input logic [7:0] r, input logic [7:0] c);
        warp_px_t w;
        if (warp_pixel(r, c, w))
            send_word(swb_pkg::ACT_REQUEST, r, c, 24'($urandom));
    endtask

    // Let the pipe empty before touching the registers.
    task automatic drain;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_px.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [swb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            swb_pkg::CFG_NUM_ROWS: geo_rows = val[8:0];
            swb_pkg::CFG_NUM_COLS: geo_cols = val[8:0];
            swb_pkg::CFG_TWIST:    geo_twist = val;
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [15:0] nr, input logic [15:0] nc,
                                input logic [15:0] tw);
        drain();
        write_reg(swb_pkg::CFG_NUM_ROWS, nr);
        write_reg(swb_pkg::CFG_NUM_COLS, nc);
        write_reg(swb_pkg::CFG_TWIST, tw);
    endtask

    // Reset geometry (256x256, default twist): a written patch at the center,
    // requests close enough that the rotated source stays on it.
    task automatic test_reset_geometry;
        for (int r = 124; r < 132; r++)
            for (int c = 124; c < 132; c++)
                if ((r + c) % 3 == 0 || (r > 125 && r < 130 && c > 125 && c < 130))
                    send_word(swb_pkg::ACT_STORE, 8'(r), 8'(c), 24'($urandom));
        for (int i = 0; i < 12; i++)
            try_request(8'($urandom_range(126, 130)), 8'($urandom_range(126, 130)));
    endtask

    // Small image with extreme colors; center, corners and far-away requests.
    task automatic test_directed;
        set_geometry(16'd4, 16'd4, 16'd572);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                send_word(swb_pkg::ACT_STORE, 8'(r), 8'(c),
                          ((r + c) % 2) ? 24'hFFFFFF : ((r == 0) ? 24'h000000 : 24'hFF00A5));
        try_request(8'd2, 8'd2);   // zero distance
        try_request(8'd0, 8'd0);
        try_request(8'd3, 8'd3);
        try_request(8'd0, 8'd3);
        try_request(8'd255, 8'd255);
        try_request(8'd0, 8'd255);
        // stray register index must not disturb anything
        drain();
        write_reg(CFG_UNUSED, 16'hFFFF);
        try_request(8'd1, 8'd2);
    endtask

    // Twist and size extremes: no rotation, maximum twist, clamped sizes.
    task automatic test_extremes;
        set_geometry(16'd4, 16'd4, 16'd0);
        for (int i = 0; i < 4; i++)
            try_request(8'(i), 8'(3 - i));
        set_geometry(16'd4, 16'd4, 16'hFFFF);
        for (int i = 0; i < 4; i++)
            try_request(8'(i), 8'(i));
        set_geometry(16'd0, 16'd0, 16'd9000);      // clamps to 1x1
        send_word(swb_pkg::ACT_STORE, 8'd0, 8'd0, 24'h80FF01);
        try_request(8'd0, 8'd0);
        try_request(8'd0, 8'd1);
        try_request(8'd200, 8'd17);
        set_geometry(16'd511, 16'd300, 16'd572);   // clamps to 256x256
        try_request(8'd128, 8'd128);
        try_request(8'd255, 8'd0);
    endtask

    // One random phase: fill an image, then mostly requests with restores.
    task automatic test_random_phase(input int send_pct, input int recv_pct,
                                     input int n_words);
        int nr, nc, tw;
        set_geometry(16'($urandom_range(2, 12)), 16'($urandom_range(2, 12)),
                     16'($urandom));
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        nr = (geo_rows > 256) ? 256 : geo_rows;
        nc = (geo_cols > 256) ? 256 : geo_cols;
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
                send_word(swb_pkg::ACT_STORE, 8'(r), 8'(c), 24'($urandom));
        for (int i = 0; i < n_words; i++)
        begin
            tw = $urandom_range(99);
            if (tw < 20)
                send_word(swb_pkg::ACT_STORE, 8'($urandom), 8'($urandom), 24'($urandom));
            else if (tw < 35)
                try_request(8'($urandom), 8'($urandom));
            else
                try_request(8'($urandom_range(nr - 1)), 8'($urandom_range(nc - 1)));
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // Receiver holds off while the sender keeps going, so the core backs up.
    task automatic test_backpressure;
        set_geometry(16'd6, 16'd8, 16'd2000);
        for (int r = 0; r < 6; r++)
            for (int c = 0; c < 8; c++)
                send_word(swb_pkg::ACT_STORE, 8'(r), 8'(c), 24'($urandom));
        recv_hold = 400;
        for (int i = 0; i < 80; i++)
            try_request(8'($urandom_range(5)), 8'($urandom_range(7)));
    endtask

    // receiver: random stalls plus the long hold-off
    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            recv_hold <= recv_hold - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker against the oldest prediction
    always @(posedge clk)
    begin
        warp_px_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_px.size() == 0)
            begin
                $error("result word with nothing expected: row %0d col %0d", out_row, out_col);
                errors++;
            end
            else
            begin
                e = pending_px.pop_front();
                if (out_row !== e.orow)
                begin
                    $error("out_row expected %0d got %0d", e.orow, out_row);
                    errors++;
                end
                if (out_col !== e.ocol)
                begin
                    $error("out_col expected %0d got %0d", e.ocol, out_col);
                    errors++;
                end
                if (red_out !== e.red)
                begin
                    $error("red_out expected %0d got %0d", e.red, red_out);
                    errors++;
                end
                if (green_out !== e.green)
                begin
                    $error("green_out expected %0d got %0d", e.green, green_out);
                    errors++;
                end
                if (blue_out !== e.blue)
                begin
                    $error("blue_out expected %0d got %0d", e.blue, blue_out);
                    errors++;
                end
                if (inside_res !== e.in_img)
                begin
                    $error("inside_res expected %0d got %0d", e.in_img, inside_res);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("swirl_warp_bilinear_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_geometry();
        test_directed();
        test_extremes();
        test_random_phase(0, 0, 70);
        test_random_phase(84, 0, 65);
        test_random_phase(0, 84, 65);
        test_random_phase(38, 38, 65);
        test_backpressure();
        drain();
        if (pending_px.size() != 0)
        begin
            $error("%0d result words never arrived", pending_px.size());
            errors++;
        end
        if (errors == 0)
            $display("swirl_warp_bilinear_core regression: pass");
        else
            $display("swirl_warp_bilinear_core regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/swb_pkg.sv
hw/rtl/swb_ram.sv
hw/rtl/swb_front.sv
hw/rtl/swb_fifo.sv
hw/rtl/swb_back.sv
hw/rtl/swirl_warp_bilinear_core.sv
tb/swirl_warp_bilinear_core_tb.sv
